// File: rtl/frc8_pkg.sv
// Shared constants, types and codes of the CRC-8 frame receiver.
package frc8_pkg;

    // Default number of bytes in one frame, check byte included.
    localparam int unsigned FRAME_BYTES_DEF = 10;

    // Reflected CRC-8 polynomial and the byte that opens a new frame.
    localparam logic [7:0] CRC_POLY  = 8'h8C;
    localparam logic [7:0] SYNC_BYTE = 8'hF5;

    // Number of frame bytes kept for the result: byte 0 and bytes 1 to 8.
    localparam int unsigned STORE_DEPTH = 9;

    typedef logic [2:0] t_kind;

    localparam t_kind KIND_NONE       = 3'd0;
    localparam t_kind KIND_CONTROLLER = 3'd1;
    localparam t_kind KIND_STATUS01   = 3'd2;
    localparam t_kind KIND_STATUS03   = 3'd3;
    localparam t_kind KIND_STATUS13   = 3'd4;

endpackage

// File: rtl/frc8_crc_step.sv
// One byte of the reflected CRC-8 update, eight shift-xor steps unrolled.
module frc8_crc_step
    import frc8_pkg::*;
(
    input  logic [7:0] i_crc,
    input  logic [7:0] i_data,
    output logic [7:0] o_crc
);

    always_comb begin
        logic [7:0] crc;
        logic [7:0] data;
        crc  = i_crc;
        data = i_data;
        for (int i = 0; i < 8; i++) begin
            if (crc[0] ^ data[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
            data = data >> 1;
        end
        o_crc = crc;
    end

endmodule

// File: rtl/frc8_classify.sv
// Frame classification from header bytes 1 and 2 and byte 8.
module frc8_classify
    import frc8_pkg::*;
(
    input  logic [7:0] i_byte1,
    input  logic [7:0] i_byte2,
    input  logic [7:0] i_byte8,
    output t_kind      o_kind
);

    always_comb begin
        priority if (i_byte1 > 8'd2 || i_byte2 > 8'd3) begin
            o_kind = KIND_NONE;
        end else if (i_byte8 == 8'd0) begin
            o_kind = KIND_CONTROLLER;
        end else if (i_byte1 == 8'd0 && i_byte2 == 8'd1) begin
            o_kind = KIND_STATUS01;
        end else if (i_byte1 == 8'd0 && i_byte2 == 8'd3) begin
            o_kind = KIND_STATUS03;
        end else if (i_byte1 == 8'd1 && i_byte2 == 8'd3) begin
            o_kind = KIND_STATUS13;
        end else begin
            o_kind = KIND_NONE;
        end
    end

endmodule

// File: rtl/frame_receiver_crc8.sv
// Frame receiver: collects fixed-length frames and checks their CRC-8 byte.
// Path: an accepted byte enters the input register; its result goes to the result register.
// Throughput: one byte per cycle while the output is not stalled; the CRC update and the
// frame bookkeeping fit in one step.
// Reset: synchronous, active low; it empties both registers and restarts frame collection,
// so the first byte after reset opens a frame whatever its value.
module frame_receiver_crc8
    import frc8_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // Result channel: exactly one result transaction per input transaction.
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_frame_done,
    output logic        o_crc_ok,
    output logic [2:0]  o_frame_kind,
    output logic [7:0]  o_start_byte,
    output logic [63:0] o_payload,
    output logic [7:0]  o_check_byte
);

    // Data bytes per frame (all but the check byte) and the width of the
    // position counter, which must be able to hold the check byte position.
    localparam int unsigned NDATA = FRAME_BYTES - 1;
    localparam int unsigned CNT_W = $clog2(FRAME_BYTES);

    // Input register.
    logic             r_in_vld;
    logic [7:0]       r_in_byte;

    // Frame state.
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_full;
    logic             n_full;
    logic [7:0]       r_crc;
    logic [7:0]       n_crc;

    // Result register.
    logic             r_out_vld;
    logic             r_done;
    logic             r_ok;
    t_kind            r_kind;
    logic [7:0]       r_start;
    logic [63:0]      r_payload;
    logic [7:0]       r_check;

    logic             w_adv;
    logic             w_fire;
    logic             w_sync;
    logic             w_idle;
    logic             w_last;
    logic             w_data;
    logic             w_ok;
    logic [7:0]       w_crc_base;
    logic [7:0]       w_crc_next;
    t_kind            w_kind;
    logic [63:0]      w_payload;
    logic [7:0]       w_store [STORE_DEPTH];

    // The result register moves on whenever it is empty or being taken. The
    // input register is stalled only when it holds a byte that cannot move.
    assign w_adv   = !(r_out_vld && i_stall);
    assign w_fire  = r_in_vld && w_adv;
    assign o_stall = r_in_vld && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // After a complete frame the counter sits at zero and bytes are dropped
    // until the sync byte arrives, which then becomes byte 0 of a new frame.
    assign w_sync = r_full && (r_in_byte == SYNC_BYTE);
    assign w_idle = r_full && !w_sync;
    assign w_last = !w_idle && (r_cnt == CNT_W'(NDATA));
    assign w_data = !w_idle && !w_last;

    // The CRC restarts from zero with byte 0 of every frame.
    assign w_crc_base = (r_cnt == '0) ? 8'h00 : r_crc;
    assign w_ok       = (w_crc_base == r_in_byte);

    frc8_crc_step u_crc (
        .i_crc  (w_crc_base),
        .i_data (r_in_byte),
        .o_crc  (w_crc_next)
    );

    always_comb begin
        n_cnt  = r_cnt;
        n_full = r_full;
        n_crc  = r_crc;
        if (w_sync) begin
            n_full = 1'b0;
        end
        if (w_data) begin
            n_cnt = r_cnt + 1'b1;
            n_crc = w_crc_next;
        end else if (w_last) begin
            n_cnt  = '0;
            n_full = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_full <= 1'b0;
            r_crc  <= 8'h00;
        end else if (w_fire) begin
            r_cnt  <= n_cnt;
            r_full <= n_full;
            r_crc  <= n_crc;
        end
    end

    // Byte store. Positions past the data bytes of a short frame are never
    // filled and read as zero. Every other position is written in each frame
    // before the check byte arrives, so no clearing is needed.
    for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_store
        if (k < NDATA) begin : g_byte
            logic [7:0] r_byte;
            always_ff @(posedge i_clk) begin
                if (w_fire && w_data && (r_cnt == CNT_W'(k))) begin
                    r_byte <= r_in_byte;
                end
            end
            assign w_store[k] = r_byte;
        end else begin : g_zero
            assign w_store[k] = 8'h00;
        end
    end

    frc8_classify u_classify (
        .i_byte1 (w_store[1]),
        .i_byte2 (w_store[2]),
        .i_byte8 (w_store[8]),
        .o_kind  (w_kind)
    );

    // Bytes 1 to 8 packed with byte 1 in the lowest lane.
    always_comb begin
        for (int k = 1; k < STORE_DEPTH; k++) begin
            w_payload[8*(k-1) +: 8] = w_store[k];
        end
    end

    // Result register. A byte that does not complete a frame still yields a
    // transaction, with every field at zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
        if (w_fire) begin
            r_done    <= w_last;
            r_ok      <= w_last && w_ok;
            r_kind    <= (w_last && w_ok) ? w_kind : KIND_NONE;
            r_start   <= w_last ? w_store[0] : 8'h00;
            r_payload <= w_last ? w_payload : 64'h0;
            r_check   <= w_last ? r_in_byte : 8'h00;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_frame_done = r_done;
    assign o_crc_ok     = r_ok;
    assign o_frame_kind = r_kind;
    assign o_start_byte = r_start;
    assign o_payload    = r_payload;
    assign o_check_byte = r_check;

    // While waiting for the sync byte the position counter stays at zero.
    ap_full_cnt_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_cnt == '0))
        else $error("frame counter moved while waiting for the sync byte");

    // The counter never passes the check byte position.
    ap_cnt_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(NDATA))
        else $error("frame counter out of range");

    // Completing a frame always arms the wait for the next sync byte.
    ap_done_sets_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_last) |=> r_full)
        else $error("frame completed without entering the sync wait");

    // A result that completes no frame carries no CRC verdict or kind.
    ap_idle_result_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_done) |-> (!o_crc_ok && o_frame_kind == KIND_NONE))
        else $error("non-final result carries frame status");

endmodule

// File: verif/frame_receiver_crc8_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the CRC-8 frame receiver: directed byte table, then random frames.
module frame_receiver_crc8_test;
    import frc8_pkg::*;

    // Frame geometry follows the default build of the receiver.
    localparam int unsigned FRAME_LEN = FRAME_BYTES_DEF;

    // Random part: how many frame bytes to send, and how many of the last
    // ones go out with no idling on either side.
    localparam int unsigned ITEM_TARGET = 1100;
    localparam int unsigned TAIL_ITEMS = 150;

    // Cycles waited after the last expected result has been checked, to cover the
    // output handshake before the run is closed.
    localparam int unsigned DRAIN_CYCLES = 8;

    // The longest gap between two transactions in a correct run comes from an idle
    // burst on the input plus a stall burst on the output.
    localparam int unsigned WATCHDOG_LIMIT = 1000;

    // One result transaction of the receiver, field by field.
    typedef struct packed {
        logic        frame_done;
        logic        crc_ok;
        t_kind       kind;
        logic [7:0]  start_byte;
        logic [63:0] payload;
        logic [7:0]  check_byte;
    } t_frame_result;

    // One row of the directed table. When typed is set, want is the result
    // that this byte must produce; otherwise the predictor supplies it.
    typedef struct packed {
        logic [7:0]    data;
        bit            typed;
        t_frame_result want;
    } t_dir_row;

    // A byte that does not complete a frame returns an all-zero result.
    localparam t_frame_result NO_FRAME = '0;

    // An all-zero frame has a CRC of zero, so a check byte of 0xFF fails.
    localparam t_frame_result BAD_ZERO_FRAME = '{
        frame_done: 1'b1,
        crc_ok:     1'b0,
        kind:       KIND_NONE,
        start_byte: 8'h00,
        payload:    64'h0,
        check_byte: 8'hFF
    };

    localparam int unsigned DIR_ROWS = 22;

    // Directed sequence:
    //  - right after reset a zero byte opens a frame; nine zero data bytes are
    //    followed by a wrong check byte,
    //  - bytes that arrive after a complete frame are ignored, both extremes,
    //  - the sync byte opens the next frame, whose further data bytes are all ones;
    //    its check byte is left to the predictor.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b1, NO_FRAME},
        '{8'h00, 1'b1, NO_FRAME},
        '{8'h00, 1'b1, NO_FRAME},
        '{8'h00, 1'b1, NO_FRAME},
        '{8'h00, 1'b1, NO_FRAME},
        '{8'h00, 1'b1, NO_FRAME},
        '{8'h00, 1'b1, NO_FRAME},
        '{8'h00, 1'b1, NO_FRAME},
        '{8'h00, 1'b1, NO_FRAME},
        '{8'hFF, 1'b1, BAD_ZERO_FRAME},
        '{8'hFF, 1'b1, NO_FRAME},
        '{8'h00, 1'b1, NO_FRAME},
        '{SYNC_BYTE, 1'b1, NO_FRAME},
        '{8'hFF, 1'b1, NO_FRAME},
        '{8'hFF, 1'b1, NO_FRAME},
        '{8'hFF, 1'b1, NO_FRAME},
        '{8'hFF, 1'b1, NO_FRAME},
        '{8'hFF, 1'b1, NO_FRAME},
        '{8'hFF, 1'b1, NO_FRAME},
        '{8'hFF, 1'b1, NO_FRAME},
        '{8'hFF, 1'b1, NO_FRAME},
        '{8'hFF, 1'b0, NO_FRAME}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_frame_done;
    logic        o_crc_ok;
    logic [2:0]  o_frame_kind;
    logic [7:0]  o_start_byte;
    logic [63:0] o_payload;
    logic [7:0]  o_check_byte;

    frame_receiver_crc8 uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_done (o_frame_done),
        .o_crc_ok     (o_crc_ok),
        .o_frame_kind (o_frame_kind),
        .o_start_byte (o_start_byte),
        .o_payload    (o_payload),
        .o_check_byte (o_check_byte)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Frame tracking state of the predictor, mirroring what the receiver
    // must hold: position in the frame, the wait for a sync byte, the running
    // CRC and the stored header and data bytes.
    int unsigned rx_pos = 0;
    bit          rx_full = 1'b0;
    logic [7:0]  rx_crc = 8'h00;
    logic [7:0]  rx_store [STORE_DEPTH];

    // Expected results in transaction order, plus run statistics.
    t_frame_result pending_q [$];
    int unsigned err_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned frame_items = 0;
    int unsigned results_seen = 0;
    int unsigned good_frames = 0;
    int unsigned bad_frames = 0;
    int unsigned kind_hits [5] = '{0, 0, 0, 0, 0};

    // Idling odds in percent, per byte offered on the input and per cycle on the output, changed between frames.
    int unsigned gap_pct = 20;
    int unsigned stall_pct = 20;
    int unsigned stall_left = 0;

    // Reflected CRC-8 over one byte, least significant bit first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        for (int i = 0; i < 8; i++) begin
            if (crc[0] ^ data[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
            data = data >> 1;
        end
        return crc;
    endfunction

    // Advances the frame tracking by one accepted byte and returns the
    // result that the receiver must give for it.
    function automatic t_frame_result frame_predict(input logic [7:0] b);
        t_frame_result res;
        logic [7:0]    b1;
        logic [7:0]    b2;
        res = '0;
        if (rx_full && b == SYNC_BYTE) begin
            rx_full = 1'b0;
            rx_pos = 0;
        end
        if (rx_full) begin
            return res;
        end
        if (rx_pos == 0) begin
            foreach (rx_store[i]) rx_store[i] = 8'h00;
            rx_crc = 8'h00;
        end
        if (rx_pos < FRAME_LEN - 1) begin
            if (rx_pos < STORE_DEPTH) begin
                rx_store[rx_pos] = b;
            end
            rx_crc = crc8_step(rx_crc, b);
            rx_pos++;
            return res;
        end
        // This byte is the check byte and closes the frame.
        b1 = rx_store[1];
        b2 = rx_store[2];
        res.frame_done = 1'b1;
        res.crc_ok = (rx_crc == b);
        res.start_byte = rx_store[0];
        for (int i = 1; i <= 8; i++) begin
            res.payload[8 * (i - 1) +: 8] = rx_store[i];
        end
        res.check_byte = b;
        res.kind = KIND_NONE;
        if (res.crc_ok && b1 <= 8'd2 && b2 <= 8'd3) begin
            if (rx_store[8] == 8'h00) begin
                res.kind = KIND_CONTROLLER;
            end else if (b1 == 8'd0 && b2 == 8'd1) begin
                res.kind = KIND_STATUS01;
            end else if (b1 == 8'd0 && b2 == 8'd3) begin
                res.kind = KIND_STATUS03;
            end else if (b1 == 8'd1 && b2 == 8'd3) begin
                res.kind = KIND_STATUS13;
            end
        end
        rx_full = 1'b1;
        rx_pos = 0;
        return res;
    endfunction

    // Idling odds for one stretch: none, light or heavy.
    function automatic int unsigned idle_odds();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    // Offers one byte on the input channel, after an optional idle burst,
    // and holds it until the receiver takes it. The valid stays high on
    // return, so back-to-back calls produce back-to-back transactions.
    task automatic send_byte(input logic [7:0] b, input bit typed, input t_frame_result want);
        t_frame_result guess;
        t_frame_result queued;
        if ($urandom_range(1, 100) <= gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        // The predictor sees every byte, even where the table fixes the result.
        guess = frame_predict(b);
        queued = typed ? want : guess;
        if (queued.frame_done) begin
            if (queued.crc_ok) begin
                good_frames++;
            end else begin
                bad_frames++;
            end
            if (queued.kind <= KIND_STATUS13) begin
                kind_hits[queued.kind]++;
            end
        end
        pending_q.push_back(queued);
        bytes_sent++;
    endtask

    // Sends one frame with random content. Most frames are well formed and
    // lean toward the header values that classify; some carry a corrupted
    // check byte, a few start with a byte other than sync, a few are cut
    // short, and line noise may come before the frame.
    task automatic send_frame();
        logic [7:0]  fr [FRAME_LEN];
        logic [7:0]  crc;
        logic [7:0]  noise;
        int unsigned n_bytes;
        n_bytes = FRAME_LEN;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                noise = 8'($urandom_range(0, 255));
                // A stray sync byte in the noise throws off the framing; let
                // that happen only now and then.
                if (noise == SYNC_BYTE && $urandom_range(0, 1) == 0) begin
                    noise = 8'h00;
                end
                send_byte(noise, 1'b0, NO_FRAME);
            end
        end
        fr[0] = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : SYNC_BYTE;
        for (int k = 1; k < FRAME_LEN; k++) begin
            fr[k] = 8'($urandom_range(0, 255));
        end
        fr[1] = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3)) : fr[1];
        fr[2] = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 4)) : fr[2];
        case ($urandom_range(0, 3))
            0, 1: fr[8] = 8'h00;
            2: fr[8] = 8'h01;
            default: ;
        endcase
        crc = 8'h00;
        for (int k = 0; k < FRAME_LEN - 1; k++) begin
            crc = crc8_step(crc, fr[k]);
        end
        case ($urandom_range(0, 9))
            0: fr[FRAME_LEN - 1] = crc ^ (8'h01 << $urandom_range(0, 7));
            1: fr[FRAME_LEN - 1] = 8'($urandom_range(0, 255));
            default: fr[FRAME_LEN - 1] = crc;
        endcase
        if (gap_pct + stall_pct != 0 && $urandom_range(0, 24) == 0) begin
            n_bytes = $urandom_range(1, FRAME_LEN - 1);
        end
        for (int k = 0; k < n_bytes; k++) begin
            send_byte(fr[k], 1'b0, NO_FRAME);
        end
        frame_items += n_bytes;
    endtask

    // Output side: random stall bursts of random length.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(1, 100) <= stall_pct) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(0, 8);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Every result transaction is matched against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_frame_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_q.size() == 0) begin
                $error("result transaction with no byte waiting for it");
                err_count++;
            end else begin
                want = pending_q.pop_front();
                if (o_frame_done !== want.frame_done) begin
                    $error("frame_done: expected %0h, got %0h", want.frame_done, o_frame_done);
                    err_count++;
                end
                if (o_crc_ok !== want.crc_ok) begin
                    $error("crc_ok: expected %0h, got %0h", want.crc_ok, o_crc_ok);
                    err_count++;
                end
                if (o_frame_kind !== want.kind) begin
                    $error("frame_kind: expected %0d, got %0d", want.kind, o_frame_kind);
                    err_count++;
                end
                if (o_start_byte !== want.start_byte) begin
                    $error("start_byte: expected %h, got %h", want.start_byte, o_start_byte);
                    err_count++;
                end
                if (o_payload !== want.payload) begin
                    $error("payload: expected %h, got %h", want.payload, o_payload);
                    err_count++;
                end
                if (o_check_byte !== want.check_byte) begin
                    $error("check_byte: expected %h, got %h", want.check_byte, o_check_byte);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: a run in which no transaction happens on either channel for
    // too long has hung, or is holding back results that are still owed.
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", pending_q.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            send_byte(dir_rows[r].data, dir_rows[r].typed, dir_rows[r].want);
        end

        // Random frames. Idling settings change every few frames; the tail of
        // the run goes at full rate on both sides.
        while (frame_items < ITEM_TARGET) begin
            if (frame_items + TAIL_ITEMS >= ITEM_TARGET) begin
                gap_pct = 0;
                stall_pct = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                gap_pct = idle_odds();
                stall_pct = idle_odds();
            end
            send_frame();
        end
        i_valid <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes (%0d in random frames), checked %0d results.",
                 bytes_sent, frame_items, results_seen);
        $display("Frames: %0d good CRC, %0d bad CRC; none/ctrl/s01/s03/s13 = %0d/%0d/%0d/%0d/%0d",
                 good_frames, bad_frames, kind_hits[0], kind_hits[1], kind_hits[2],
                 kind_hits[3], kind_hits[4]);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: frame_receiver_crc8.f
rtl/frc8_pkg.sv
rtl/frc8_crc_step.sv
rtl/frc8_classify.sv
rtl/frame_receiver_crc8.sv
verif/frame_receiver_crc8_test.sv
